@@ sv/fked_pkg.sv @@
// Shared types and constants for the five-key event decoder.
package fked_pkg;

    // Configuration register file
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 24'd40000;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 24'd3000000;

    // Key vector layout
    localparam int KEY_W = 5;
    localparam int K_UP  = 0;
    localparam int K_DN  = 1;
    localparam int K_TOP = 2;
    localparam int K_BOT = 3;
    localparam int K_OK  = 4;

    // Debounced levels after this item and before it
    typedef struct packed {
        logic [KEY_W-1:0] cur;
        logic [KEY_W-1:0] prev;
    } keys_t;

    // Event flags of one item
    typedef struct packed {
        logic chord;
        logic up;
        logic down;
        logic confirm;
        logic cancel;
        logic long_cancel;
    } events_t;

endpackage

@@ sv/fked_debounce.sv @@
// Debounce filter: raw sample tracking and settle-time compare.
module fked_debounce #(
    parameter int TIME_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [TIME_BITS-1:0]    now,
    input  logic [fked_pkg::KEY_W-1:0] sample,
    input  logic [fked_pkg::CFG_W-1:0] debounce_time,
    output fked_pkg::keys_t         keys
);
    import fked_pkg::*;

    logic [KEY_W-1:0]     raw_reg;
    logic [TIME_BITS-1:0] last_change_reg;
    logic [KEY_W-1:0]     stable_reg;
    logic [KEY_W-1:0]     stable_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 changed;
    logic                 settled;

    // Settle check; a fresh change restarts the timer at zero
    always_comb
    begin
        changed = (sample != raw_reg);
        elapsed = now - last_change_reg;
        if (changed)
        begin
            settled = (debounce_time == '0);
        end
        else
        begin
            settled = (elapsed >= {{(TIME_BITS-CFG_W){1'b0}}, debounce_time});
        end
        stable_next = settled ? sample : stable_reg;
        keys.cur    = stable_next;
        keys.prev   = stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg         <= '0;
            last_change_reg <= '0;
            stable_reg      <= '0;
        end
        else if (step)
        begin
            raw_reg    <= sample;
            stable_reg <= stable_next;
            if (changed)
            begin
                last_change_reg <= now;
            end
        end
    end

endmodule

@@ sv/fked_events.sv @@
// Event logic: edges, chord latch and bottom-key long press.
module fked_events #(
    parameter int TIME_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [TIME_BITS-1:0]    now,
    input  fked_pkg::keys_t         keys,
    input  logic [fked_pkg::CFG_W-1:0] long_press_time,
    output fked_pkg::events_t       events
);
    import fked_pkg::*;

    logic                 chord_reg;
    logic                 chord_next;
    logic                 long_done_reg;
    logic                 long_done_next;
    logic [TIME_BITS-1:0] bot_time_reg;
    logic [TIME_BITS-1:0] held;
    logic [KEY_W-1:0]     rise;
    logic                 bot_rise;
    logic                 long_done_eff;
    logic                 long_due;

    always_comb
    begin
        rise          = keys.cur & ~keys.prev;
        bot_rise      = rise[K_BOT];
        held          = now - bot_time_reg;
        // a new bottom press restarts the hold timer on this item
        long_done_eff = bot_rise ? 1'b0 : long_done_reg;
        if (bot_rise)
        begin
            long_due = (long_press_time == '0);
        end
        else
        begin
            long_due = (held >= {{(TIME_BITS-CFG_W){1'b0}}, long_press_time});
        end

        events         = '0;
        chord_next     = chord_reg;
        long_done_next = long_done_reg;
        if (keys.cur[K_TOP] && keys.cur[K_BOT])
        begin
            // chord: one event per press, swallows the bottom release
            if (!chord_reg)
            begin
                chord_next     = 1'b1;
                long_done_next = 1'b1;
                events.chord   = 1'b1;
            end
        end
        else
        begin
            chord_next     = 1'b0;
            long_done_next = long_done_eff;
            events.up      = rise[K_UP];
            events.down    = rise[K_DN];
            events.confirm = rise[K_TOP] | rise[K_OK];
            events.cancel  = !keys.cur[K_BOT] && keys.prev[K_BOT] && !long_done_eff;
            if (keys.cur[K_BOT] && !long_done_eff && long_due)
            begin
                long_done_next     = 1'b1;
                events.long_cancel = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chord_reg     <= 1'b0;
            long_done_reg <= 1'b0;
            bot_time_reg  <= '0;
        end
        else if (step)
        begin
            chord_reg     <= chord_next;
            long_done_reg <= long_done_next;
            if (bot_rise && !(keys.cur[K_TOP] && keys.cur[K_BOT]))
            begin
                bot_time_reg <= now;
            end
        end
    end

endmodule

@@ sv/five_key_event_decoder.sv @@
// Top level of the five-key event decoder: config registers, item and result stages.
//
// One key poll item in, one result item out, at a sustained rate of one item per
// clock while out_stall is low. An accepted item is held in the input register
// and its result is then written to the output register. The per-item path is one
// TIME_BITS-wide subtract and compare for the debounce timer and one for the
// long-press timer, run side by side. While a result waits under out_stall the
// input register still takes one more item, so in_stall rises only when both
// stages are full. Configuration writes take effect on the next item processed and
// should be made while no item is in flight.
module five_key_event_decoder #(
    parameter int TIME_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_write,
    input  logic [fked_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fked_pkg::CFG_W-1:0] cfg_data,
    // input items
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [TIME_BITS-1:0]    time_us,
    input  logic                    up_pressed,
    input  logic                    down_pressed,
    input  logic                    top_pressed,
    input  logic                    bottom_pressed,
    input  logic                    ok_pressed,
    // result items
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    chord_event,
    output logic                    up_event,
    output logic                    down_event,
    output logic                    confirm_event,
    output logic                    cancel_event,
    output logic                    long_cancel_event,
    output logic                    any_action,
    output logic [fked_pkg::KEY_W-1:0] debounced_keys
);
    import fked_pkg::*;

    logic [CFG_W-1:0]     debounce_reg;
    logic [CFG_W-1:0]     long_press_reg;

    logic                 in_vld_reg;
    logic [TIME_BITS-1:0] in_time_reg;
    logic [KEY_W-1:0]     in_keys_reg;
    logic                 out_vld_reg;
    events_t              out_ev_reg;
    logic [KEY_W-1:0]     out_keys_reg;

    logic                 advance;
    logic                 step;
    logic                 in_take;
    keys_t                keys;
    events_t              events;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Flow control
    assign advance  = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (advance || !in_vld_reg)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_time_reg <= time_us;
            in_keys_reg <= {ok_pressed, bottom_pressed, top_pressed,
                            down_pressed, up_pressed};
        end
    end

    fked_debounce #(
        .TIME_BITS     (TIME_BITS)
    ) u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .now           (in_time_reg),
        .sample        (in_keys_reg),
        .debounce_time (debounce_reg),
        .keys          (keys)
    );

    fked_events #(
        .TIME_BITS       (TIME_BITS)
    ) u_events (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .now             (in_time_reg),
        .keys            (keys),
        .long_press_time (long_press_reg),
        .events          (events)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_ev_reg   <= events;
            out_keys_reg <= keys.cur;
        end
    end

    assign out_valid         = out_vld_reg;
    assign chord_event       = out_ev_reg.chord;
    assign up_event          = out_ev_reg.up;
    assign down_event        = out_ev_reg.down;
    assign confirm_event     = out_ev_reg.confirm;
    assign cancel_event      = out_ev_reg.cancel;
    assign long_cancel_event = out_ev_reg.long_cancel;
    assign any_action        = |out_ev_reg;
    assign debounced_keys    = out_keys_reg;

endmodule

@@ sv/fked_checker.sv @@
// Port-level checks for the five-key event decoder, bound to the top level.
module fked_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       chord_event,
    input logic       up_event,
    input logic       down_event,
    input logic       confirm_event,
    input logic       cancel_event,
    input logic       long_cancel_event,
    input logic       any_action,
    input logic [4:0] debounced_keys
);

    // summary flag tracks the six events
    a_any: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_action == (chord_event | up_event | down_event |
                       confirm_event | cancel_event | long_cancel_event)))
        else $error("any_action does not match event flags");

    // chord only with top and bottom held, and then no other event
    a_chord: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && chord_event) |-> (debounced_keys[2] && debounced_keys[3] &&
            !up_event && !down_event && !confirm_event && !cancel_event &&
            !long_cancel_event))
        else $error("chord event with wrong key state");

    // cancel needs bottom up, long cancel needs bottom down
    a_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(cancel_event && debounced_keys[3]) &&
                       !(long_cancel_event && !debounced_keys[3])))
        else $error("bottom key event with wrong level");

    // stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(any_action) &&
                                      $stable(debounced_keys)))
        else $error("stalled result changed");

endmodule

bind five_key_event_decoder fked_checker u_fked_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .chord_event       (chord_event),
    .up_event          (up_event),
    .down_event        (down_event),
    .confirm_event     (confirm_event),
    .cancel_event      (cancel_event),
    .long_cancel_event (long_cancel_event),
    .any_action        (any_action),
    .debounced_keys    (debounced_keys)
);

@@ tb/sv/fked_checker.sv @@
// Checker for the five-key event decoder: predicts each result item and compares it.
module fked_scoreboard #(
    parameter int TIME_BITS = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fked_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fked_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [TIME_BITS-1:0]             time_us,
    input  logic                             up_pressed,
    input  logic                             down_pressed,
    input  logic                             top_pressed,
    input  logic                             bottom_pressed,
    input  logic                             ok_pressed,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             chord_event,
    input  logic                             up_event,
    input  logic                             down_event,
    input  logic                             confirm_event,
    input  logic                             cancel_event,
    input  logic                             long_cancel_event,
    input  logic                             any_action,
    input  logic [fked_pkg::KEY_W-1:0]       debounced_keys,
    output int                               mismatch_count,
    output int                               results_due
);
    import fked_pkg::*;

    typedef struct packed {
        events_t          ev;
        logic             any;
        logic [KEY_W-1:0] keys;
    } key_result_t;

    // shadow of the configuration registers
    logic [CFG_W-1:0]     settle_us;
    logic [CFG_W-1:0]     hold_us;

    // shadow of the decoder state
    logic [KEY_W-1:0]     raw_keys;
    logic [KEY_W-1:0]     settled_keys;
    logic [TIME_BITS-1:0] change_stamp;
    logic [TIME_BITS-1:0] bottom_stamp;
    logic                 chord_held;
    logic                 hold_reported;

    key_result_t          due_results[$];
    key_result_t          want;
    key_result_t          fresh;

    // Work out the result of one key poll and advance the shadow state
    task automatic decode_poll(input logic [TIME_BITS-1:0] now,
                               input logic [KEY_W-1:0] sample,
                               output key_result_t r);
        logic [KEY_W-1:0]     prev_k;
        logic [KEY_W-1:0]     cur_k;
        logic [KEY_W-1:0]     rise;
        logic [TIME_BITS-1:0] since_change;
        logic [TIME_BITS-1:0] since_press;
        r = '0;
        prev_k = settled_keys;
        if (sample != raw_keys)
        begin
            raw_keys = sample;
            change_stamp = now;
        end
        // differences wrap modulo 2^TIME_BITS
        since_change = now - change_stamp;
        if (since_change >= TIME_BITS'(settle_us))
            settled_keys = raw_keys;
        cur_k = settled_keys;
        rise = cur_k & ~prev_k;

        if (cur_k[K_TOP] && cur_k[K_BOT])
        begin
            // chord: one event per hold, and it eats the bottom release
            if (!chord_held)
            begin
                chord_held = 1'b1;
                hold_reported = 1'b1;
                r.ev.chord = 1'b1;
            end
        end
        else
        begin
            chord_held = 1'b0;
            r.ev.up = rise[K_UP];
            r.ev.down = rise[K_DN];
            r.ev.confirm = rise[K_TOP] | rise[K_OK];
            if (rise[K_BOT])
            begin
                bottom_stamp = now;
                hold_reported = 1'b0;
            end
            if (!cur_k[K_BOT] && prev_k[K_BOT] && !hold_reported)
                r.ev.cancel = 1'b1;
            since_press = now - bottom_stamp;
            if (cur_k[K_BOT] && !hold_reported && since_press >= TIME_BITS'(hold_us))
            begin
                hold_reported = 1'b1;
                r.ev.long_cancel = 1'b1;
            end
        end
        r.any = |r.ev;
        r.keys = cur_k;
    endtask

    function automatic void check_field(string field, logic [KEY_W-1:0] exp_v,
                                        logic [KEY_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatch_count++;
            $error("%s: expected %0h, got %0h", field, exp_v, got_v);
        end
    endfunction

    // Watch config writes, accepted results and accepted polls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_us = DEBOUNCE_RESET;
            hold_us = LONG_PRESS_RESET;
            raw_keys = '0;
            settled_keys = '0;
            change_stamp = '0;
            bottom_stamp = '0;
            chord_held = 1'b0;
            hold_reported = 1'b0;
            due_results.delete();
            mismatch_count = 0;
            results_due = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEBOUNCE:   settle_us = cfg_data;
                    REG_LONG_PRESS: hold_us = cfg_data;
                    default:        ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    $error("result item with no poll waiting for it");
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("chord_event", KEY_W'(want.ev.chord), KEY_W'(chord_event));
                    check_field("up_event", KEY_W'(want.ev.up), KEY_W'(up_event));
                    check_field("down_event", KEY_W'(want.ev.down), KEY_W'(down_event));
                    check_field("confirm_event", KEY_W'(want.ev.confirm),
                                KEY_W'(confirm_event));
                    check_field("cancel_event", KEY_W'(want.ev.cancel),
                                KEY_W'(cancel_event));
                    check_field("long_cancel_event", KEY_W'(want.ev.long_cancel),
                                KEY_W'(long_cancel_event));
                    check_field("any_action", KEY_W'(want.any), KEY_W'(any_action));
                    check_field("debounced_keys", want.keys, debounced_keys);
                end
            end

            if (in_valid && !in_stall)
            begin
                decode_poll(time_us, {ok_pressed, bottom_pressed, top_pressed,
                                      down_pressed, up_pressed}, fresh);
                due_results.push_back(fresh);
            end
            results_due = due_results.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the five-key event decoder: clock, reset, key poll stimulus, verdict.
module tb;
    import fked_pkg::*;

    localparam int TIME_BITS   = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_POLLS = 290;

    // indexes past the register file; writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [CFG_W-1:0]     CFG_MAX  = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // key masks
    localparam logic [KEY_W-1:0] M_UP  = KEY_W'(1) << K_UP;
    localparam logic [KEY_W-1:0] M_DN  = KEY_W'(1) << K_DN;
    localparam logic [KEY_W-1:0] M_TOP = KEY_W'(1) << K_TOP;
    localparam logic [KEY_W-1:0] M_BOT = KEY_W'(1) << K_BOT;
    localparam logic [KEY_W-1:0] M_OK  = KEY_W'(1) << K_OK;
    localparam logic [KEY_W-1:0] M_ALL = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [TIME_BITS-1:0]   time_us = '0;
    logic                   up_pressed = 1'b0;
    logic                   down_pressed = 1'b0;
    logic                   top_pressed = 1'b0;
    logic                   bottom_pressed = 1'b0;
    logic                   ok_pressed = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   chord_event;
    logic                   up_event;
    logic                   down_event;
    logic                   confirm_event;
    logic                   cancel_event;
    logic                   long_cancel_event;
    logic                   any_action;
    logic [KEY_W-1:0]       debounced_keys;
    int                     mismatch_count;
    int                     results_due;

    // stimulus state
    logic [TIME_BITS-1:0]   now_us = '0;
    int unsigned            settle_cur = DEBOUNCE_RESET;
    int unsigned            hold_cur = LONG_PRESS_RESET;
    int                     polls_sent = 0;
    bit                     idling_on = 1'b1;
    bit                     sender_busy = 1'b1;

    // receiver stall bursts
    int                     stall_left = 0;
    int                     stretch_left = 0;
    bit                     stretch_busy = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    five_key_event_decoder #(.TIME_BITS(TIME_BITS)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .time_us(time_us),
        .up_pressed(up_pressed),
        .down_pressed(down_pressed),
        .top_pressed(top_pressed),
        .bottom_pressed(bottom_pressed),
        .ok_pressed(ok_pressed),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .chord_event(chord_event),
        .up_event(up_event),
        .down_event(down_event),
        .confirm_event(confirm_event),
        .cancel_event(cancel_event),
        .long_cancel_event(long_cancel_event),
        .any_action(any_action),
        .debounced_keys(debounced_keys)
    );

    fked_scoreboard #(.TIME_BITS(TIME_BITS)) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .time_us(time_us),
        .up_pressed(up_pressed),
        .down_pressed(down_pressed),
        .top_pressed(top_pressed),
        .bottom_pressed(bottom_pressed),
        .ok_pressed(ok_pressed),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .chord_event(chord_event),
        .up_event(up_event),
        .down_event(down_event),
        .confirm_event(confirm_event),
        .cancel_event(cancel_event),
        .long_cancel_event(long_cancel_event),
        .any_action(any_action),
        .debounced_keys(debounced_keys),
        .mismatch_count(mismatch_count),
        .results_due(results_due)
    );

    // Result side: stall bursts inside busy stretches, quiet stretches between
    always @(negedge clk)
    begin
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(20, 200);
            stretch_busy = $urandom_range(0, 2) != 0;
        end
        else
            stretch_left--;
        if (stall_left == 0 && idling_on && stretch_busy && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 14);
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Present one poll at a falling edge and hold it until accepted
    task automatic drive_poll(input logic [TIME_BITS-1:0] t, input logic [KEY_W-1:0] k);
        @(negedge clk);
        if (idling_on && sender_busy && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        time_us <= t;
        up_pressed <= k[K_UP];
        down_pressed <= k[K_DN];
        top_pressed <= k[K_TOP];
        bottom_pressed <= k[K_BOT];
        ok_pressed <= k[K_OK];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic step_keys(input logic [KEY_W-1:0] k, input logic [TIME_BITS-1:0] delta);
        now_us = now_us + delta;
        drive_poll(now_us, k);
        polls_sent++;
    endtask

    // Stop sending and wait until every result has come back
    task automatic settle_block;
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] settle_v, input logic [CFG_W-1:0] hold_v);
        settle_block();
        write_reg(REG_DEBOUNCE, settle_v);
        write_reg(REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_LONG_PRESS, hold_v);
        write_reg(REG_SPARE_HI, CFG_W'($urandom));
        settle_cur = 32'(settle_v);
        hold_cur = 32'(hold_v);
    endtask

    // Time step between polls: zero, backward, random or scaled to settle and hold times
    function automatic logic [TIME_BITS-1:0] pick_delta();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return TIME_MAX - TIME_BITS'($urandom_range(0, 49));   // clock steps back
            2, 3:    return TIME_BITS'(hold_cur + $urandom_range(0, 3));
            4:       return TIME_BITS'({$urandom(), $urandom()});
            5, 6, 7: return TIME_BITS'($urandom_range(settle_cur / 2, settle_cur + 2));
            default: return TIME_BITS'($urandom_range(0, settle_cur / 2 + 2));
        endcase
    endfunction

    // One key gesture: some contact bounce, then a held key pattern
    task automatic gesture;
        logic [KEY_W-1:0] target;
        target = '0;
        sender_busy = ($urandom_range(0, 1) != 0);
        case ($urandom_range(0, 9))
            0:       target = M_UP;
            1:       target = M_DN;
            2:       target = M_TOP;
            3:       target = M_BOT;
            4:       target = M_OK;
            5, 6:    target = M_TOP | M_BOT;
            7:       target = KEY_W'($urandom);
            8:       target = KEY_W'($urandom) | M_BOT;
            default: target = '0;
        endcase
        repeat ($urandom_range(0, 3))
            step_keys(KEY_W'($urandom), TIME_BITS'($urandom_range(0, settle_cur / 4 + 1)));
        repeat ($urandom_range(1, 5))
            step_keys(target, pick_delta());
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] settle_v, input logic [CFG_W-1:0] hold_v);
        int goal;
        configure(settle_v, hold_v);
        goal = polls_sent + PHASE_POLLS;
        while (polls_sent < goal)
            gesture();
    endtask

    // Hard stop
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: press settles only after the debounce time
        drive_poll(0, '0);
        drive_poll(1000, M_UP | M_OK);
        drive_poll(41000, M_UP | M_OK);
        drive_poll(41500, M_ALL);

        // zero debounce and zero hold: chord, then no cancel on the bottom release
        configure('0, '0);
        drive_poll(41600, M_ALL);
        drive_poll(41700, M_BOT);
        drive_poll(41800, '0);

        // hold never reached: plain cancel, chord suppresses the cancel
        configure('0, CFG_MAX);
        drive_poll(41900, M_BOT | M_DN);
        drive_poll(41901, '0);
        drive_poll(41902, M_TOP | M_BOT);
        drive_poll(41903, M_TOP | M_BOT);
        drive_poll(41904, M_TOP);
        drive_poll(41905, '0);
        drive_poll(41906, M_TOP);

        // timestamp wrap, clock going backwards, long press
        configure(10, 20);
        drive_poll(TIME_MAX - 3, M_DN);
        drive_poll(TIME_MAX, M_DN);
        drive_poll(5, M_DN);
        drive_poll(6, M_DN);
        drive_poll(3, M_UP);
        drive_poll(2, M_UP);
        drive_poll(100, M_BOT);
        drive_poll(110, M_BOT);
        drive_poll(125, M_BOT);
        drive_poll(130, M_BOT);
        now_us = 130;

        // random gestures under several settings
        run_phase('0, '0);
        run_phase(5, 40);
        run_phase(CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(1, 3000)));
        run_phase(CFG_MAX, CFG_MAX);
        now_us = TIME_MAX - TIME_BITS'($urandom_range(0, 5000));
        run_phase(CFG_W'($urandom_range(1, 1000)), CFG_W'($urandom_range(1, 5000)));
        idling_on = 1'b0;
        run_phase(20, 100);

        settle_block();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
